/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/anfc_pkg.sv */
// Types and constants of the Annex B NAL frame classifier.
package anfc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned TYPE_W = 5;
	localparam int unsigned COUNT_W = 3;
	localparam int unsigned RUN_W = 2;
	localparam int unsigned RES_W = 6;
	localparam int unsigned M_DATA_W = 8;

	localparam logic [BYTE_W-1:0] HDR_TYPE_MASK = 8'h1f;
	localparam int unsigned SLICE_BIT = 7;
	localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 3'd5;
	localparam logic [RUN_W-1:0] START_ZEROS = 2'd2;
	localparam logic [BYTE_W-1:0] START_MARK = 8'h01;

	localparam logic [TYPE_W-1:0] NAL_SLICE = 5'd1;
	localparam logic [TYPE_W-1:0] NAL_IDR = 5'd5;
	localparam logic [TYPE_W-1:0] NAL_SEI = 5'd6;
	localparam logic [TYPE_W-1:0] NAL_SPS = 5'd7;
	localparam logic [TYPE_W-1:0] NAL_PPS = 5'd8;
	localparam logic [TYPE_W-1:0] NAL_AUD = 5'd9;

	// One input word.
	typedef struct packed {
		logic              frame_end;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	// One result; the last member sits in the lowest bit.
	typedef struct packed {
		logic first_slice_start;
		logic saw_sei_or_aud;
		logic saw_param_set;
		logic saw_slice;
		logic droppable;
		logic config_only;
	} res_t;

endpackage

/* hdl/anfc_in_reg.sv */
// Input register stage holding one accepted word.
module anfc_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  anfc_pkg::item_t item,
	input  logic          advance,
	output logic          valid_s1,
	output anfc_pkg::item_t item_s1
);
	import anfc_pkg::*;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item;
		end
	end

endmodule

/* hdl/anfc_scan.sv */
// Start code scanner, NAL type tracking and result formation.
module anfc_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  anfc_pkg::item_t item_s1,
	output anfc_pkg::res_t  res,
	output logic            res_load
);
	import anfc_pkg::*;

	logic [RUN_W-1:0]   zero_run_q, zero_run_n;
	logic               header_due_q, header_due_n;
	logic               slice_due_q, slice_due_n;
	logic               seen_slice_q, seen_slice_n;
	logic               seen_param_q, seen_param_n;
	logic               seen_sei_q, seen_sei_n;
	logic               vcl_found_q, vcl_found_n;
	logic               fsb_q, fsb_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic [BYTE_W-1:0]  b;
	logic [TYPE_W-1:0]  hdr_type;
	logic               long_enough;

	assign b = item_s1.data_byte;
	assign hdr_type = TYPE_W'(b & HDR_TYPE_MASK);

	always_comb begin
		zero_run_n = zero_run_q;
		header_due_n = header_due_q;
		slice_due_n = 1'b0;
		seen_slice_n = seen_slice_q;
		seen_param_n = seen_param_q;
		seen_sei_n = seen_sei_q;
		vcl_found_n = vcl_found_q;
		fsb_n = slice_due_q ? b[SLICE_BIT] : fsb_q;
		count_n = (count_q < MIN_FRAME_LEN) ? count_q + COUNT_W'(1) : count_q;

		if (header_due_q) begin
			// The header byte never takes part in a start code.
			if (hdr_type inside {NAL_SLICE, NAL_IDR}) begin
				seen_slice_n = 1'b1;
			end else if (hdr_type inside {NAL_SPS, NAL_PPS}) begin
				seen_param_n = 1'b1;
			end else if (hdr_type inside {NAL_SEI, NAL_AUD}) begin
				seen_sei_n = 1'b1;
			end
			if (!vcl_found_q && (hdr_type inside {[NAL_SLICE:NAL_IDR]})) begin
				vcl_found_n = 1'b1;
				slice_due_n = 1'b1;
			end
			header_due_n = 1'b0;
			zero_run_n = '0;
		end else if (b == '0) begin
			if (zero_run_q < START_ZEROS) begin
				zero_run_n = zero_run_q + RUN_W'(1);
			end
		end else if (b == START_MARK && zero_run_q >= START_ZEROS) begin
			header_due_n = 1'b1;
			zero_run_n = '0;
		end else begin
			zero_run_n = '0;
		end
	end

	assign long_enough = (count_n >= MIN_FRAME_LEN);

	always_comb begin
		res.saw_slice = long_enough && seen_slice_n;
		res.saw_param_set = long_enough && seen_param_n;
		res.saw_sei_or_aud = long_enough && seen_sei_n;
		res.config_only = !res.saw_slice && res.saw_param_set;
		res.droppable = !res.saw_slice && !res.saw_param_set && res.saw_sei_or_aud;
		res.first_slice_start = fsb_n;
	end

	assign res_load = step && item_s1.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q <= '0;
			header_due_q <= 1'b0;
			slice_due_q <= 1'b0;
			seen_slice_q <= 1'b0;
			seen_param_q <= 1'b0;
			seen_sei_q <= 1'b0;
			vcl_found_q <= 1'b0;
			fsb_q <= 1'b1;
			count_q <= '0;
		end else if (step) begin
			if (item_s1.frame_end) begin
				// The frame is done; start the next one from scratch.
				zero_run_q <= '0;
				header_due_q <= 1'b0;
				slice_due_q <= 1'b0;
				seen_slice_q <= 1'b0;
				seen_param_q <= 1'b0;
				seen_sei_q <= 1'b0;
				vcl_found_q <= 1'b0;
				fsb_q <= 1'b1;
				count_q <= '0;
			end else begin
				zero_run_q <= zero_run_n;
				header_due_q <= header_due_n;
				slice_due_q <= slice_due_n;
				seen_slice_q <= seen_slice_n;
				seen_param_q <= seen_param_n;
				seen_sei_q <= seen_sei_n;
				vcl_found_q <= vcl_found_n;
				fsb_q <= fsb_n;
				count_q <= count_n;
			end
		end
	end

endmodule

/* hdl/anfc_out_reg.sv */
// Result register driving the master side.
module anfc_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  anfc_pkg::res_t                 res,
	output logic                           room,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [anfc_pkg::M_DATA_W-1:0]  m_tdata
);
	import anfc_pkg::*;

	res_t res_q;

	assign room = !m_tvalid || m_tready;
	assign m_tdata = {(M_DATA_W-RES_W)'(0), res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (room) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

/* hdl/annexb_nal_frame_classifier.sv */
// Top level of the Annex B NAL frame classifier.
//
// The slave side takes one frame byte per word, with s_tlast on the final
// byte of the frame. The block looks for 00 00 01 start codes, classifies
// each NAL header that follows and, on the final byte only, sends one word
// on the master side with the frame's classification flags.
// Throughput is one byte per cycle, except while a final byte waits for a
// free result register. An accepted word sits in the input register and is
// scanned from there; the result of a final byte is loaded into the result
// register, which drives m_tvalid and m_tdata.
// Bytes that are not final never need the result register, so they keep
// flowing while a finished result waits for m_tready. A final byte waits in
// the input register only while the result register is still occupied, and
// s_tready drops for just that case.
// Reset empties both registers and puts the scanner at the start of a frame.
// Frames shorter than five bytes report all type flags as zero.
module annexb_nal_frame_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // frame_end
	output logic       m_tvalid,
	input  logic       m_tready,
	// [0] config_only, [1] droppable, [2] saw_slice, [3] saw_param_set,
	// [4] saw_sei_or_aud, [5] first_slice_start, [7:6] zero
	output logic [7:0] m_tdata
);
	import anfc_pkg::*;

	item_t item;
	item_t item_s1;
	logic  valid_s1;
	logic  step;
	logic  room;
	logic  res_load;
	res_t  res;

	assign item.data_byte = s_tdata;
	assign item.frame_end = s_tlast;

	// Only a final byte needs a free result register to move on.
	assign step = valid_s1 && (!item_s1.frame_end || room);

	anfc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.item     (item),
		.advance  (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	anfc_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item_s1  (item_s1),
		.res      (res),
		.res_load (res_load)
	);

	anfc_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_load),
		.res      (res),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* hdl/anfc_checker.sv */
// Port-level checks of the classifier, bound to its top level.
`include "assert_macros.svh"

module anfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A result word waiting on the master side stays up and unchanged.
	`ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// The slave side may only block behind a stalled result word.
	`ASSERT_IMP(a_block_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)

	// A stalled slave side must not be caused by an idle sender alone.
	`ASSERT_IMP(a_ready_idle, clk, arst_n, !s_tvalid && !m_tvalid, s_tready)

	// The summary flags must agree with the per-type flags, and bits 7:6 must be zero.
	`ASSERT_IMP(a_flag_sense, clk, arst_n, m_tvalid,
		(m_tdata[0] == (m_tdata[3] && !m_tdata[2])) &&
		(m_tdata[1] == (m_tdata[4] && !m_tdata[3] && !m_tdata[2])) &&
		(m_tdata[7:6] == 2'b00))

endmodule

bind annexb_nal_frame_classifier anfc_checker u_anfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* dv/tb_annexb_nal_frame_classifier.sv */
// Testbench for the Annex B NAL frame classifier: directed table, random frames, predictor.
`timescale 1ns / 100ps

module tb_annexb_nal_frame_classifier;
	import anfc_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int N_DIRECTED = 29;

	// One row of the directed table. Where known is set, res holds the typed-in result.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              known;
		res_t              res;
	} step_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;

	int snd_idle;
	int rcv_stall;
	int errors;
	int quiet_cycles = 0;

	// Scanner state of the predictor.
	logic [RUN_W-1:0]   zero_run;
	logic               header_due;
	logic               slice_byte_due;
	logic               seen_slice;
	logic               seen_param;
	logic               seen_sei;
	logic               vcl_found;
	logic               fs_bit;
	logic [COUNT_W-1:0] byte_cnt;

	res_t frame_flags_due[$];
	logic [BYTE_W-1:0] frame_bytes[$];

	// Bytes of the directed frames, with the final byte of each frame marked.
	step_row_t directed_rows [N_DIRECTED] = '{
		// Short frame: the IDR header is the fourth and final byte, all type flags stay zero.
		{8'h00, 1'b0, 1'b0, 6'h00}, {8'h00, 1'b0, 1'b0, 6'h00},
		{8'h01, 1'b0, 1'b0, 6'h00}, {8'h65, 1'b1, 1'b1, 6'b100000},
		// SPS with the high header bits set, then an all-ones byte.
		{8'h00, 1'b0, 1'b0, 6'h00}, {8'h00, 1'b0, 1'b0, 6'h00},
		{8'h01, 1'b0, 1'b0, 6'h00}, {8'hE7, 1'b0, 1'b0, 6'h00},
		{8'hFF, 1'b1, 1'b0, 6'h00},
		// AUD only, and a start code that ends the frame: droppable.
		{8'h00, 1'b0, 1'b0, 6'h00}, {8'h00, 1'b0, 1'b0, 6'h00},
		{8'h01, 1'b0, 1'b0, 6'h00}, {8'h09, 1'b0, 1'b0, 6'h00},
		{8'h00, 1'b0, 1'b0, 6'h00}, {8'h00, 1'b0, 1'b0, 6'h00},
		{8'h01, 1'b1, 1'b1, 6'b110010},
		// Non-IDR slice whose next byte has bit 7 clear.
		{8'h00, 1'b0, 1'b0, 6'h00}, {8'h00, 1'b0, 1'b0, 6'h00},
		{8'h01, 1'b0, 1'b0, 6'h00}, {8'h41, 1'b0, 1'b0, 6'h00},
		{8'h7F, 1'b1, 1'b0, 6'h00},
		// SEI, then an IDR header as the final byte.
		{8'h00, 1'b0, 1'b0, 6'h00}, {8'h00, 1'b0, 1'b0, 6'h00},
		{8'h01, 1'b0, 1'b0, 6'h00}, {8'h06, 1'b0, 1'b0, 6'h00},
		{8'h00, 1'b0, 1'b0, 6'h00}, {8'h00, 1'b0, 1'b0, 6'h00},
		{8'h01, 1'b0, 1'b0, 6'h00}, {8'h05, 1'b1, 1'b0, 6'h00}
	};

	annexb_nal_frame_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_frame();
		zero_run = '0;
		header_due = 1'b0;
		slice_byte_due = 1'b0;
		seen_slice = 1'b0;
		seen_param = 1'b0;
		seen_sei = 1'b0;
		vcl_found = 1'b0;
		fs_bit = 1'b1;
		byte_cnt = '0;
	endfunction

	// Advances the scanner by one byte; on the final byte it returns the frame's flags.
	function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic last,
			output bit done, output res_t res);
		logic [TYPE_W-1:0] nal;
		logic long_frame;
		logic s, p, e;
		done = 1'b0;
		res = '0;
		if (byte_cnt < MIN_FRAME_LEN)
			byte_cnt++;
		if (slice_byte_due) begin
			fs_bit = b[SLICE_BIT];
			slice_byte_due = 1'b0;
		end
		if (header_due) begin
			nal = TYPE_W'(b & HDR_TYPE_MASK);
			if (nal == NAL_SLICE || nal == NAL_IDR)
				seen_slice = 1'b1;
			else if (nal == NAL_SPS || nal == NAL_PPS)
				seen_param = 1'b1;
			else if (nal == NAL_SEI || nal == NAL_AUD)
				seen_sei = 1'b1;
			// Types 2 to 4 are VCL too, so they also claim the first-slice byte.
			if (!vcl_found && nal >= NAL_SLICE && nal <= NAL_IDR) begin
				vcl_found = 1'b1;
				slice_byte_due = 1'b1;
			end
			header_due = 1'b0;
			zero_run = '0;
		end else if (b == 8'h00) begin
			if (zero_run < START_ZEROS)
				zero_run++;
		end else if (b == START_MARK && zero_run >= START_ZEROS) begin
			header_due = 1'b1;
			zero_run = '0;
		end else begin
			zero_run = '0;
		end
		if (last) begin
			long_frame = (byte_cnt >= MIN_FRAME_LEN);
			s = long_frame && seen_slice;
			p = long_frame && seen_param;
			e = long_frame && seen_sei;
			res.config_only = !s && p;
			res.droppable = !s && e && !p;
			res.saw_slice = s;
			res.saw_param_set = p;
			res.saw_sei_or_aud = e;
			res.first_slice_start = fs_bit;
			done = 1'b1;
			clear_frame();
		end
	endfunction

	function automatic logic [7:0] pick_header();
		logic [TYPE_W-1:0] nal;
		case ($urandom_range(7))
			0: nal = NAL_SLICE;
			1: nal = NAL_IDR;
			2: nal = NAL_SEI;
			3: nal = NAL_SPS;
			4: nal = NAL_PPS;
			5: nal = NAL_AUD;
			6: nal = TYPE_W'($urandom_range(2, 4));
			default: nal = TYPE_W'($urandom_range(31));
		endcase
		return {3'($urandom_range(7)), nal};
	endfunction

	// Mostly frames of well-formed NAL units with random payload; some short and noise frames.
	function automatic void build_frame();
		int kind, units, zeros, plen;
		frame_bytes.delete();
		kind = $urandom_range(9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 4))
				frame_bytes.push_back($urandom_range(2) == 0 ? 8'($urandom_range(1)) :
					8'($urandom_range(255)));
		end else if (kind == 1) begin
			repeat ($urandom_range(5, 20))
				frame_bytes.push_back($urandom_range(3) == 0 ? 8'($urandom_range(1)) :
					8'($urandom_range(255)));
		end else begin
			units = $urandom_range(1, 4);
			for (int u = 0; u < units; u++) begin
				// A single leading zero now and then gives a broken start code.
				zeros = ($urandom_range(11) == 0) ? 1 : $urandom_range(2, 4);
				repeat (zeros)
					frame_bytes.push_back(8'h00);
				frame_bytes.push_back(START_MARK);
				// The frame may end right after a start code or right after a header.
				if (u == units - 1 && $urandom_range(9) == 0)
					break;
				frame_bytes.push_back(pick_header());
				if (u == units - 1 && $urandom_range(7) == 0)
					break;
				plen = $urandom_range(0, 6);
				repeat (plen)
					frame_bytes.push_back($urandom_range(7) == 0 ? 8'($urandom_range(1)) :
						8'($urandom_range(255)));
			end
		end
	endfunction

	task automatic send_word(input logic [7:0] b, input logic last, input logic known,
			input res_t given);
		bit done;
		res_t res;
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		scan_byte(b, last, done, res);
		if (done)
			frame_flags_due.push_back(known ? given : res);
	endtask

	// Drops tvalid and holds the sender off until every pending result has come back.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (frame_flags_due.size() != 0);
	endtask

	task automatic run_phase(input int snd, input int rcv, input int n_bytes);
		int sent;
		snd_idle = snd;
		rcv_stall = rcv;
		sent = 0;
		while (sent < n_bytes) begin
			build_frame();
			foreach (frame_bytes[i])
				send_word(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
			sent += frame_bytes.size();
		end
		wait_for_results();
	endtask

	function automatic void check_field(input string name, input logic want,
			input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			errors++;
		end
	endfunction

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= rcv_stall);
		end
	end

	always @(posedge clk) begin : result_check
		res_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[RES_W-1:0]);
			if (frame_flags_due.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				errors++;
			end else begin
				want = frame_flags_due.pop_front();
				check_field("config_only", want.config_only, got.config_only);
				check_field("droppable", want.droppable, got.droppable);
				check_field("saw_slice", want.saw_slice, got.saw_slice);
				check_field("saw_param_set", want.saw_param_set, got.saw_param_set);
				check_field("saw_sei_or_aud", want.saw_sei_or_aud, got.saw_sei_or_aud);
				check_field("first_slice_start", want.first_slice_start,
					got.first_slice_start);
				if (m_tdata[7:6] !== 2'b00) begin
					$error("pad: expected 00, got %b", m_tdata[7:6]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		snd_idle = 0;
		rcv_stall = 0;
		clear_frame();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(directed_rows[i].data, directed_rows[i].last, directed_rows[i].known,
				directed_rows[i].res);
		wait_for_results();

		run_phase(25, 54, 700);
		run_phase(54, 25, 700);
		run_phase(0, 0, 600);

		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (frame_flags_due.size() != 0) begin
			$error("%0d frame results never arrived", frame_flags_due.size());
			errors++;
		end
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
